/* rtl/soa_pkg.sv */
// ----------------------------------------------------------------------------
// soa_pkg
// Shared types and codes of the slab object allocator: request and result
// items, the decoded command, configuration fields and status codes.
// ----------------------------------------------------------------------------
package soa_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_OBJECT_SIZE = 2'd0;
  localparam logic [1:0] CFG_USABLE_SPAN = 2'd1;
  localparam logic [1:0] CFG_PAGE_ORDER  = 2'd2;

  localparam int unsigned CfgDataW = 15;

  // Reset values of the configuration registers
  localparam logic [12:0] OBJECT_SIZE_RST = 13'd8;
  localparam logic [14:0] USABLE_SPAN_RST = 15'd4096;
  localparam logic [1:0]  PAGE_ORDER_RST  = 2'd0;

  // Result status codes
  localparam logic [1:0] STATUS_ALLOC_OK   = 2'd0;
  localparam logic [1:0] STATUS_ALLOC_FAIL = 2'd1;
  localparam logic [1:0] STATUS_FREED      = 2'd2;
  localparam logic [1:0] STATUS_FREE_DROP  = 2'd3;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    BK_IDLE = 1'b0,
    BK_READ = 1'b1
  } back_state_e;

  typedef struct packed {
    logic        mode;
    logic [31:0] free_address;
    logic [31:0] offered_page_base;
    logic        offered_page_valid;
  } req_t;

  typedef struct packed {
    logic [31:0] object_address;
    logic [1:0]  status;
    logic        page_taken;
  } rsp_t;

  typedef struct packed {
    op_e         op;
    logic [31:0] free_address;
    logic [31:0] offered_page_base;
    logic        offered_page_valid;
  } cmd_t;

  typedef struct packed {
    logic [12:0] object_size;
    logic [14:0] usable_span;
    logic [1:0]  page_order;
  } cfg_t;

  // Back end status seen by the top level
  typedef struct packed {
    logic reading;
    logic stack_empty;
  } back_stat_t;

endpackage

/* rtl/soa_front.sv */
// ----------------------------------------------------------------------------
// soa_front
// Request front end: accepts items into a two-entry queue and decodes the
// mode into an allocate or free command for the back end.
// ----------------------------------------------------------------------------
module soa_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  soa_pkg::req_t req_i,
  output logic          cmd_valid_o,
  output soa_pkg::cmd_t cmd_o,
  input  logic          cmd_take_i
);
  import soa_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       wr_en;
  logic       rd_en;
  cmd_t       cmd_in;

  // Decode the incoming item
  always_comb begin
    cmd_in.op                 = req_i.mode ? OP_FREE : OP_ALLOC;
    cmd_in.free_address       = req_i.free_address;
    cmd_in.offered_page_base  = req_i.offered_page_base;
    cmd_in.offered_page_valid = req_i.offered_page_valid;
  end

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = entry_q[rd_ptr_q];
  assign wr_en       = push && !full;
  assign rd_en       = cmd_take_i && cmd_valid_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_en ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = rd_en ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 2'd1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Hold queued commands
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

/* rtl/soa_back.sv */
// ----------------------------------------------------------------------------
// soa_back
// Allocator back end: free stack memory, carving pointer into the current
// slab, and the result register.
// ----------------------------------------------------------------------------
module soa_back #(
  parameter int unsigned FREE_DEPTH = 256,
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  soa_pkg::cfg_t       cfg_i,
  input  logic                cmd_valid_i,
  input  soa_pkg::cmd_t       cmd_i,
  output logic                cmd_take_o,
  output logic                out_valid_o,
  output soa_pkg::rsp_t       out_o,
  input  logic                out_pop_i,
  output soa_pkg::back_stat_t stat_o
);
  import soa_pkg::*;

  localparam int unsigned IdxW  = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(FREE_DEPTH + 1);
  localparam int unsigned LimRaw = $clog2(PAGE_BYTES) + 3;
  localparam int unsigned LimW  = (LimRaw > 16) ? LimRaw : 16;

  back_state_e state_q, state_d;

  logic [31:0]     stack_mem [FREE_DEPTH];
  logic [31:0]     rd_data_q;
  logic [CntW-1:0] count_q, count_d;
  logic [14:0]     carve_q, carve_d;
  logic [31:0]     base_q, base_d;
  logic            page_q, page_d;
  logic            out_valid_q, out_valid_d;
  rsp_t            out_q, out_d;

  logic            slot_free;
  logic            fire;
  logic            stack_full;
  logic            stack_empty;
  logic            push_en;
  logic            pop_en;
  logic            carve_en;
  logic            load_out;
  logic [IdxW-1:0] wr_idx;
  logic [IdxW-1:0] rd_idx;
  logic [CntW-1:0] count_dec;

  logic [LimW-1:0] limit;
  logic [LimW-1:0] span_ext;
  logic [14:0]     start;
  logic [14:0]     size_ext;
  logic            room_cur;
  logic            room_start;
  logic            take;
  logic            carve_ok;
  logic [14:0]     off_use;
  logic [31:0]     base_use;
  logic [14:0]     new_off;
  logic [31:0]     carve_addr;

  assign stack_full  = (count_q == CntW'(FREE_DEPTH));
  assign stack_empty = (count_q == '0);
  assign count_dec   = count_q - CntW'(1);
  assign wr_idx      = count_q[IdxW-1:0];
  assign rd_idx      = count_dec[IdxW-1:0];

  // Slab room check and page refill
  always_comb begin
    size_ext   = {2'b00, cfg_i.object_size};
    limit      = LimW'(PAGE_BYTES) << cfg_i.page_order;
    span_ext   = LimW'(cfg_i.usable_span);
    start      = (span_ext < limit) ? cfg_i.usable_span : limit[14:0];
    room_cur   = page_q && (carve_q != '0) && (carve_q >= size_ext);
    room_start = (start != '0) && (start >= size_ext);
    take       = !room_cur && cmd_i.offered_page_valid && room_start;
    carve_ok   = room_cur || take;
    off_use    = take ? start : carve_q;
    base_use   = take ? cmd_i.offered_page_base : base_q;
    new_off    = off_use - size_ext;
    carve_addr = base_use + {17'd0, new_off};
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (pop_en) begin
          state_d = BK_READ;
        end
      end
      BK_READ: begin
        state_d = BK_IDLE;
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  // Issue control
  always_comb begin
    slot_free  = !out_valid_q || out_pop_i;
    fire       = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        fire     = cmd_valid_i && slot_free;
        load_out = fire && !(cmd_i.op == OP_ALLOC && !stack_empty);
      end
      BK_READ: begin
        load_out = 1'b1;
      end
      default: begin
        fire     = 1'b0;
        load_out = 1'b0;
      end
    endcase
    cmd_take_o = fire;
    push_en    = fire && (cmd_i.op == OP_FREE) && !stack_full;
    pop_en     = fire && (cmd_i.op == OP_ALLOC) && !stack_empty;
    carve_en   = fire && (cmd_i.op == OP_ALLOC) && stack_empty;
  end

  // Build the result and update allocator state
  always_comb begin
    count_d = count_q;
    carve_d = carve_q;
    base_d  = base_q;
    page_d  = page_q;
    out_d.object_address = '0;
    out_d.status         = STATUS_ALLOC_OK;
    out_d.page_taken     = 1'b0;
    if (state_q == BK_READ) begin
      out_d.object_address = rd_data_q;
    end else if (cmd_i.op == OP_FREE) begin
      out_d.status = stack_full ? STATUS_FREE_DROP : STATUS_FREED;
    end else if (carve_ok) begin
      out_d.object_address = carve_addr;
      out_d.page_taken     = take;
    end else begin
      out_d.status = STATUS_ALLOC_FAIL;
    end
    if (push_en) begin
      count_d = count_q + CntW'(1);
    end else if (pop_en) begin
      count_d = count_dec;
    end
    if (carve_en && carve_ok) begin
      carve_d = new_off;
      base_d  = base_use;
      page_d  = 1'b1;
    end
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      count_q     <= '0;
      carve_q     <= '0;
      base_q      <= '0;
      page_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      carve_q     <= carve_d;
      base_q      <= base_d;
      page_q      <= page_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Free stack memory with registered read
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      stack_mem[wr_idx] <= cmd_i.free_address;
    end
    if (pop_en) begin
      rd_data_q <= stack_mem[rd_idx];
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_o              = out_q;
  assign stat_o.reading     = (state_q == BK_READ);
  assign stat_o.stack_empty = stack_empty;

endmodule

/* rtl/slab_object_allocator.sv */
// A free or carved allocation loads the result register when its item is accepted;
// a stack allocation first registers the stack memory read, then loads the result.
// Throughput: one free or carved allocation per cycle while results are taken;
// a stack allocation holds the back end in its read state, so no new item is taken.
// Reset: asynchronous, clears the free count, the slab state and all queues;
// the stack memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// slab_object_allocator
// Fixed-size object allocator with a bounded free stack and slab carving,
// queue-style request and result channels, and a plain configuration port.
// ----------------------------------------------------------------------------
module slab_object_allocator #(
  parameter int unsigned FREE_DEPTH = 256,
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  soa_pkg::req_t                    req_i,
  output logic                             empty,
  input  logic                             pop,
  output soa_pkg::rsp_t                    rsp_o,
  input  logic                             cfg_we_i,
  input  logic [1:0]                       cfg_idx_i,
  input  logic [soa_pkg::CfgDataW-1:0]     cfg_wdata_i
);
  import soa_pkg::*;

  cfg_t       cfg_q;
  logic       cmd_valid;
  cmd_t       cmd;
  logic       cmd_take;
  logic       out_valid;
  back_stat_t stat;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.object_size <= OBJECT_SIZE_RST;
      cfg_q.usable_span <= USABLE_SPAN_RST;
      cfg_q.page_order  <= PAGE_ORDER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OBJECT_SIZE: cfg_q.object_size <= cfg_wdata_i[12:0];
        CFG_USABLE_SPAN: cfg_q.usable_span <= cfg_wdata_i[14:0];
        CFG_PAGE_ORDER:  cfg_q.page_order  <= cfg_wdata_i[1:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  soa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  soa_back #(
    .FREE_DEPTH (FREE_DEPTH),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .out_valid_o (out_valid),
    .out_o       (rsp_o),
    .out_pop_i   (pop && out_valid),
    .stat_o      (stat)
  );

  assign empty = !out_valid;

  // A stack read starts only into an empty result slot
  a_read_slot_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.reading |-> empty)
    else $error("stack read with result slot occupied");

  // Stack read data lands in the result slot
  a_read_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.reading |=> !empty)
    else $error("stack read produced no result");

  // A stack read only follows a nonempty stack
  a_read_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(stat.reading) |-> $past(!stat.stack_empty))
    else $error("stack read from empty stack");

endmodule
